// File: rtl/pidc_pkg.sv
package pidc_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 12;
	localparam int SUM_WIDTH_DEF      = 40;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int PC_W       = 4;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN       = 3'd0,
		REG_INTEG_GAIN      = 3'd1,
		REG_DERIV_GAIN      = 3'd2,
		REG_INTEGRAL_WINDOW = 3'd3,
		REG_DRIVE_CEILING   = 3'd4,
		REG_DRIVE_FLOOR     = 3'd5,
		REG_SENSOR_SCALE    = 3'd6,
		REG_CONTROL_ENABLE  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] prop_gain;
		logic signed [23:0] integ_gain;
		logic signed [23:0] deriv_gain;
		logic [30:0]        integral_window;
		logic signed [15:0] drive_ceiling;
		logic signed [15:0] drive_floor;
		logic [15:0]        sensor_scale;
		logic               control_enable;
	} cfg_t;

	// control word fields
	typedef enum logic [1:0] {MA_SCALE, MA_KP, MA_KI, MA_KD} mul_a_t;
	typedef enum logic [2:0] {MB_COUNT, MB_ERR, MB_DERIV, MB_SUM_LO, MB_SUM_HI} mul_b_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_ADD, ACC_ADD_HI} acc_op_t;
	typedef enum logic [1:0] {ST_NONE, ST_ERR, ST_UPD, ST_CLR} st_op_t;
	typedef enum logic [1:0] {FIN_NONE, FIN_RUN, FIN_ZERO} fin_t;
	typedef enum logic {COND_NEVER, COND_DISABLED} cond_t;

	typedef struct packed {
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            mul_en;
		mul_a_t          ma;
		mul_b_t          mb;
		acc_op_t         acc;
		st_op_t          st;
		fin_t            fin;
	} ctl_t;

	// program steps
	localparam logic [PC_W-1:0] STEP_MUL_POS = 4'd0;
	localparam logic [PC_W-1:0] STEP_ERR     = 4'd1;
	localparam logic [PC_W-1:0] STEP_UPD_KP  = 4'd2;
	localparam logic [PC_W-1:0] STEP_KD      = 4'd3;
	localparam logic [PC_W-1:0] STEP_KI_LO   = 4'd4;
	localparam logic [PC_W-1:0] STEP_KI_HI   = 4'd5;
	localparam logic [PC_W-1:0] STEP_ACC_HI  = 4'd6;
	localparam logic [PC_W-1:0] STEP_FINISH  = 4'd7;
	localparam logic [PC_W-1:0] STEP_OFF     = 4'd8;
	localparam logic [PC_W-1:0] STEP_LAST    = STEP_OFF;

	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{COND_NEVER, STEP_MUL_POS, 1'b0, MA_SCALE, MB_COUNT, ACC_HOLD, ST_NONE, FIN_NONE};
		case (pc)
			STEP_MUL_POS: begin
				w.cond   = COND_DISABLED;
				w.target = STEP_OFF;
				w.mul_en = 1'b1;
			end
			STEP_ERR: begin
				w.st = ST_ERR;
			end
			STEP_UPD_KP: begin
				w.st     = ST_UPD;
				w.acc    = ACC_CLEAR;
				w.mul_en = 1'b1;
				w.ma     = MA_KP;
				w.mb     = MB_ERR;
			end
			STEP_KD: begin
				w.acc    = ACC_ADD;
				w.mul_en = 1'b1;
				w.ma     = MA_KD;
				w.mb     = MB_DERIV;
			end
			STEP_KI_LO: begin
				w.acc    = ACC_ADD;
				w.mul_en = 1'b1;
				w.ma     = MA_KI;
				w.mb     = MB_SUM_LO;
			end
			STEP_KI_HI: begin
				w.acc    = ACC_ADD;
				w.mul_en = 1'b1;
				w.ma     = MA_KI;
				w.mb     = MB_SUM_HI;
			end
			STEP_ACC_HI: begin
				w.acc = ACC_ADD_HI;
			end
			STEP_FINISH: begin
				w.fin = FIN_RUN;
			end
			STEP_OFF: begin
				w.st  = ST_CLR;
				w.fin = FIN_ZERO;
			end
			default: begin
				w.fin = FIN_ZERO;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/pidc_if.sv
interface pidc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sensor_count;
	logic signed [31:0] target_value;

	modport source(output valid, output sensor_count, output target_value, input ready);
	modport sink(input valid, input sensor_count, input target_value, output ready);
endinterface

interface pidc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive;
	logic signed [31:0] error_value;

	modport source(output valid, output drive, output error_value, input ready);
	modport sink(input valid, input drive, input error_value, output ready);
endinterface

// File: rtl/pidc_dp.sv
module pidc_dp
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int SUM_WIDTH      = SUM_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  ctl_t               ctl,
	input  logic               step_en,
	input  logic               load_in,
	input  logic signed [31:0] sensor_count,
	input  logic signed [31:0] target_value,
	output logic signed [15:0] drive,
	output logic signed [31:0] error_value
);

	localparam int PROD_W = 58;
	localparam int ACC_W  = SUM_WIDTH + 27;
	localparam int SUMX_W = 65;
	localparam logic signed [50:0] ERR_MAX = 51'sd2147483647;
	localparam logic signed [50:0] ERR_MIN = -51'sd2147483648;
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic signed [31:0]          count_q, target_q;
	logic signed [PROD_W-1:0]    p_q;
	logic signed [31:0]          err_q, prev_q;
	logic signed [32:0]          deriv_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [ACC_W-1:0]     acc_q;

	logic signed [24:0]          mul_a;
	logic signed [32:0]          mul_b;
	logic signed [PROD_W-1:0]    prod;
	logic [SUMX_W-1:0]           sum_x;
	logic signed [49:0]          pos;
	logic signed [50:0]          err_w;
	logic signed [31:0]          err_sat;
	logic [31:0]                 err_mag;
	logic                        integrate;
	logic signed [SUM_WIDTH:0]   sum_w;
	logic signed [SUM_WIDTH-1:0] sum_sat;
	logic signed [32:0]          deriv_d;
	logic signed [ACC_W-1:0]     p_ext, acc_sh, ceil_x, floor_x, clamp_hi, clamp_lo;

	assign sum_x = {{(SUMX_W-SUM_WIDTH){sum_q[SUM_WIDTH-1]}}, sum_q};

	always_comb begin
		case (ctl.ma)
			MA_SCALE: mul_a = {9'b0, cfg.sensor_scale};
			MA_KP:    mul_a = {cfg.prop_gain[23], cfg.prop_gain};
			MA_KI:    mul_a = {cfg.integ_gain[23], cfg.integ_gain};
			MA_KD:    mul_a = {cfg.deriv_gain[23], cfg.deriv_gain};
			default:  mul_a = '0;
		endcase
		case (ctl.mb)
			MB_COUNT:  mul_b = {count_q[31], count_q};
			MB_ERR:    mul_b = {err_q[31], err_q};
			MB_DERIV:  mul_b = deriv_q;
			MB_SUM_LO: mul_b = {1'b0, sum_x[31:0]};
			MB_SUM_HI: mul_b = sum_x[64:32];
			default:   mul_b = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	// error: floor(count*scale/256) - target, saturated to 32 bits
	assign pos   = p_q[PROD_W-1:8];
	assign err_w = {pos[49], pos} - {{19{target_q[31]}}, target_q};
	always_comb begin
		if (err_w > ERR_MAX)
			err_sat = ERR_MAX[31:0];
		else if (err_w < ERR_MIN)
			err_sat = ERR_MIN[31:0];
		else
			err_sat = err_w[31:0];
	end

	// integral window and saturating sum
	assign err_mag   = err_q[31] ? (~err_q + 32'd1) : err_q;
	assign integrate = (cfg.integ_gain != '0) && (err_mag < {1'b0, cfg.integral_window});
	assign sum_w     = {sum_q[SUM_WIDTH-1], sum_q}
	                 + {{(SUM_WIDTH+1-32){err_q[31]}}, err_q};
	always_comb begin
		if (sum_w[SUM_WIDTH] != sum_w[SUM_WIDTH-1])
			sum_sat = sum_w[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		else
			sum_sat = sum_w[SUM_WIDTH-1:0];
	end
	assign deriv_d = {err_q[31], err_q} - {prev_q[31], prev_q};

	// output: floor shift, ceiling clamp first, floor clamp last
	assign p_ext    = {{(ACC_W-PROD_W){p_q[PROD_W-1]}}, p_q};
	assign acc_sh   = acc_q >>> GAIN_FRAC_BITS;
	assign ceil_x   = {{(ACC_W-16){cfg.drive_ceiling[15]}}, cfg.drive_ceiling};
	assign floor_x  = {{(ACC_W-16){cfg.drive_floor[15]}}, cfg.drive_floor};
	assign clamp_hi = (acc_sh > ceil_x) ? ceil_x : acc_sh;
	assign clamp_lo = (clamp_hi < floor_x) ? floor_x : clamp_hi;

	assign drive       = (ctl.fin == FIN_RUN) ? clamp_lo[15:0] : '0;
	assign error_value = (ctl.fin == FIN_RUN) ? err_q : '0;

	always_ff @(posedge clk) begin
		if (load_in) begin
			count_q  <= sensor_count;
			target_q <= target_value;
		end
		if (step_en && ctl.mul_en)
			p_q <= prod;
		if (step_en && ctl.st == ST_ERR)
			err_q <= err_sat;
		if (step_en && ctl.st == ST_UPD)
			deriv_q <= deriv_d;
		if (step_en) begin
			case (ctl.acc)
				ACC_CLEAR:  acc_q <= '0;
				ACC_ADD:    acc_q <= acc_q + p_ext;
				ACC_ADD_HI: acc_q <= acc_q + (p_ext <<< 32);
				default:    acc_q <= acc_q;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
		end else if (step_en) begin
			case (ctl.st)
				ST_UPD: begin
					prev_q <= err_q;
					sum_q  <= integrate ? sum_sat : '0;
				end
				ST_CLR: begin
					prev_q <= '0;
					sum_q  <= '0;
				end
				default: begin
					prev_q <= prev_q;
					sum_q  <= sum_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/pid_position_controller.sv
// channel  dir  handshake          payload
// in_ch    in   valid/ready        sensor_count s32, target_value s32
// out_ch   out  valid/ready        drive s16, error_value s32
// cfg      in   cfg_we (no ready)  cfg_index 3b, cfg_data 31b
//
// An enabled request runs the steps up to STEP_FINISH, a disabled one jumps to STEP_OFF;
// the microcode program steps one shared 25x33 multiplier through the scale and
// the three gain products.
// A new request is accepted once the program is back at rest, also while a result
// still waits in the output register; the last step stalls until that register is free.
// arst_n clears the sequencer, controller state and config registers to their reset values.
module pid_position_controller
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int SUM_WIDTH      = SUM_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pidc_in_if.sink               in_ch,
	pidc_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg_q;
	logic               busy_q;
	logic [PC_W-1:0]    pc_q;
	ctl_t               ctl;
	logic               accept;
	logic               finishing;
	logic               stall;
	logic               step_en;
	logic               take_jump;
	logic               out_valid_q;
	logic signed [15:0] drive_q;
	logic signed [31:0] err_out_q;
	logic signed [15:0] dp_drive;
	logic signed [31:0] dp_err;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= '0;
			cfg_q.integ_gain      <= '0;
			cfg_q.deriv_gain      <= '0;
			cfg_q.integral_window <= 31'd50;
			cfg_q.drive_ceiling   <= 16'sd127;
			cfg_q.drive_floor     <= -16'sd127;
			cfg_q.sensor_scale    <= 16'd256;
			cfg_q.control_enable  <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:       cfg_q.prop_gain       <= cfg_data[23:0];
				REG_INTEG_GAIN:      cfg_q.integ_gain      <= cfg_data[23:0];
				REG_DERIV_GAIN:      cfg_q.deriv_gain      <= cfg_data[23:0];
				REG_INTEGRAL_WINDOW: cfg_q.integral_window <= cfg_data;
				REG_DRIVE_CEILING:   cfg_q.drive_ceiling   <= cfg_data[15:0];
				REG_DRIVE_FLOOR:     cfg_q.drive_floor     <= cfg_data[15:0];
				REG_SENSOR_SCALE:    cfg_q.sensor_scale    <= cfg_data[15:0];
				REG_CONTROL_ENABLE:  cfg_q.control_enable  <= cfg_data[0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// sequencer: fetch the control word for the current step
	assign ctl       = ucode(pc_q);
	assign accept    = in_ch.valid && in_ch.ready;
	assign finishing = busy_q && (ctl.fin != FIN_NONE);
	// hold the last step while the previous result is still unclaimed
	assign stall     = finishing && out_valid_q && !out_ch.ready;
	assign step_en   = busy_q && !stall;
	assign take_jump = (ctl.cond == COND_DISABLED) && !cfg_q.control_enable;

	assign in_ch.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_MUL_POS;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= STEP_MUL_POS;
		end else if (step_en) begin
			if (take_jump)
				pc_q <= ctl.target;
			else if (ctl.fin != FIN_NONE)
				busy_q <= 1'b0;
			else
				pc_q <= pc_q + 4'd1;
		end
	end

	pidc_dp #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.SUM_WIDTH     (SUM_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.ctl         (ctl),
		.step_en     (step_en),
		.load_in     (accept),
		.sensor_count(in_ch.sensor_count),
		.target_value(in_ch.target_value),
		.drive       (dp_drive),
		.error_value (dp_err)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finishing && step_en)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finishing && step_en) begin
			drive_q   <= dp_drive;
			err_out_q <= dp_err;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.drive       = drive_q;
	assign out_ch.error_value = err_out_q;

	// checks
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= STEP_LAST)
		else $error("step counter ran past the program");

	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && pc_q == STEP_MUL_POS)
		else $error("program did not start on a request");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !cfg_q.control_enable |->
			out_ch.drive == 16'sd0 && out_ch.error_value == 32'sd0)
		else $error("nonzero result while control is off");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && cfg_q.control_enable && cfg_q.drive_floor <= cfg_q.drive_ceiling |->
			out_ch.drive <= cfg_q.drive_ceiling && out_ch.drive >= cfg_q.drive_floor)
		else $error("drive outside clamp range");

endmodule
